// ===== hw/rtl/mrbg_pkg.sv =====
package mrbg_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_BLOCK  = 4096;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 13;
  localparam int QS_W   = 5;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int FILL_W = $clog2(MAX_BLOCK);
  localparam int SUM_W  = 20;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_QUANT_SHIFT  = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_W-1:0] cfg_t;

  function automatic cfg_t clamp_cfg(input cfg_t v, input cfg_t hi);
    cfg_t r;
    if (v == '0) begin
      r = cfg_t'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/med_residual_block_golomb_param.sv =====
// Median edge predictor with block-wise Golomb parameter. Luma pixels enter in raster
// order, one request per cycle while in_ready is high; each request gives one result:
// the quantized residual, and on the last residual of a block the block's Golomb
// parameter (the floored mean absolute residual, at least 1, at most 255) plus the
// zero-pad count if the frame ended on a short block. The row above lives in a 4096 x 8
// synchronous row memory, read one column ahead to be ready for the next request. A
// request that closes a block holds off requests while a bit-serial divider forms the
// mean (an overflow check, then eight restoring steps unless it saturates) for output.
// Configuration must only be written while the block is idle.
module med_residual_block_golomb_param (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [mrbg_pkg::IDX_W-1:0] cfg_index,
  input  logic [mrbg_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mrbg_pkg::PIX_W-1:0] in_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [7:0]         out_residual,
  output logic                      out_block_end,
  output logic [7:0]                out_block_param,
  output logic [11:0]               out_pad_count,
  output logic                      out_frame_end
);
  import mrbg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  cfg_t             width_r, height_r, bsize_r;
  logic [QS_W-1:0]  qshift_r;

  logic [1:0]       state_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  pix_t             left_r, uleft_r;
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0] sum_r;

  pix_t             row_mem [MAX_WIDTH];
  pix_t             rdata_r;
  logic             fwd_r;
  pix_t             fwd_px_r;

  logic [SUM_W-1:0] rem_r;
  logic [7:0]       quo_r;
  logic [2:0]       step_r;
  logic signed [7:0] hres_r;
  logic [11:0]      hpad_r;
  logic             hfe_r;

  logic             out_valid_r;
  logic signed [7:0] out_res_r;
  logic             out_bend_r;
  logic [7:0]       out_param_r;
  logic [11:0]      out_pad_r;
  logic             out_fe_r;

  cfg_t             w_eff, h_eff, bs_eff;
  logic [QS_W-1:0]  qs_eff;
  logic             out_free, accept, out_load;
  pix_t             above, pred, mx, mn;
  logic signed [8:0] diff, shifted;
  logic signed [7:0] res;
  logic [7:0]       mag;
  logic [CFG_W-1:0] col_inc, row_inc, fill_inc;
  logic             row_end, frame_end, bend;
  logic [COL_W-1:0] col_nxt, rd_addr;
  logic [SUM_W-1:0] sum_nxt;
  logic [11:0]      pad;
  logic [SUM_W:0]   div_sh;
  logic             div_ge, ovf;

  assign w_eff  = clamp_cfg(width_r, cfg_t'(MAX_WIDTH));
  assign h_eff  = clamp_cfg(height_r, cfg_t'(MAX_HEIGHT));
  assign bs_eff = clamp_cfg(bsize_r, cfg_t'(MAX_BLOCK));
  assign qs_eff = (qshift_r == '0) ? QS_W'(1) : qshift_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign out_load = (accept && !bend) || (state_r == ST_DONE && out_free);

  // prediction
  assign above = fwd_r ? fwd_px_r : rdata_r;
  assign mx    = (left_r > above) ? left_r : above;
  assign mn    = (left_r > above) ? above : left_r;

  always_comb begin
    if (row_r == '0 && col_r == '0) begin
      pred = '0;
    end else if (row_r == '0) begin
      pred = left_r;
    end else if (col_r == '0) begin
      pred = above;
    end else if (uleft_r >= mx) begin
      pred = mn;
    end else if (uleft_r <= mn) begin
      pred = mx;
    end else begin
      pred = PIX_W'({1'b0, left_r} + {1'b0, above} - {1'b0, uleft_r});
    end
  end

  assign diff    = $signed({1'b0, in_pixel}) - $signed({1'b0, pred});
  assign shifted = diff >>> qs_eff;
  assign res     = shifted[7:0];
  assign mag     = res[7] ? 8'(-res) : 8'(res);

  assign col_inc   = {1'b0, col_r} + cfg_t'(1);
  assign row_inc   = {1'b0, row_r} + cfg_t'(1);
  assign fill_inc  = {1'b0, fill_r} + cfg_t'(1);
  assign row_end   = col_inc >= w_eff;
  assign frame_end = row_end && (row_inc >= h_eff);
  assign bend      = (fill_inc >= bs_eff) || frame_end;
  assign pad       = (fill_inc >= bs_eff) ? 12'd0 : 12'(bs_eff - fill_inc);
  assign sum_nxt   = sum_r + SUM_W'(mag);
  assign col_nxt   = row_end ? '0 : col_inc[COL_W-1:0];
  assign rd_addr   = accept ? col_nxt : col_r;

  // divider
  assign div_sh = {{(SUM_W+1-CFG_W){1'b0}}, bs_eff} << step_r;
  assign div_ge = {1'b0, rem_r} >= div_sh;
  assign ovf    = {1'b0, rem_r} >= {bs_eff, 8'b0};

  // row memory, one column read ahead
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col_r] <= in_pixel;
    end
    rdata_r  <= row_mem[rd_addr];
    fwd_px_r <= in_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cfg_t'(MAX_WIDTH);
      height_r <= cfg_t'(MAX_HEIGHT);
      bsize_r  <= cfg_t'(64);
      qshift_r <= QS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        REG_BLOCK_SIZE:   bsize_r  <= cfg_wdata;
        REG_QUANT_SHIFT:  qshift_r <= cfg_wdata[QS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      uleft_r     <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      fwd_r <= accept && (rd_addr == col_r);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            left_r  <= in_pixel;
            uleft_r <= above;
            col_r   <= col_nxt;
            if (row_end) begin
              row_r <= frame_end ? '0 : row_inc[ROW_W-1:0];
            end
            if (bend) begin
              fill_r  <= '0;
              sum_r   <= '0;
              rem_r   <= sum_nxt;
              quo_r   <= '0;
              hres_r  <= res;
              hpad_r  <= pad;
              hfe_r   <= frame_end;
              state_r <= ST_OVF;
            end else begin
              fill_r      <= fill_inc[FILL_W-1:0];
              sum_r       <= sum_nxt;
              out_res_r   <= res;
              out_bend_r  <= 1'b0;
              out_param_r <= '0;
              out_pad_r   <= '0;
              out_fe_r    <= frame_end;
            end
          end
        end
        ST_OVF: begin
          if (ovf) begin
            quo_r   <= 8'hFF;
            state_r <= ST_DONE;
          end else begin
            step_r  <= 3'd7;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_r <= {quo_r[6:0], div_ge};
          if (div_ge) begin
            rem_r <= rem_r - div_sh[SUM_W-1:0];
          end
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r - 3'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_res_r   <= hres_r;
            out_bend_r  <= 1'b1;
            out_param_r <= (quo_r == '0) ? 8'd1 : quo_r;
            out_pad_r   <= hpad_r;
            out_fe_r    <= hfe_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_residual    = out_res_r;
  assign out_block_end   = out_bend_r;
  assign out_block_param = out_param_r;
  assign out_pad_count   = out_pad_r;
  assign out_frame_end   = out_fe_r;

  a_param_only_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_block_end |-> out_block_param == 8'd0 && out_pad_count == 12'd0)
    else $error("param or pad without block end");

  a_param_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_block_param != 8'd0)
    else $error("zero golomb parameter on block end");

  a_pad_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pad_count != 12'd0 |-> out_frame_end && out_block_end)
    else $error("pad outside frame end");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r != 3'd0 |=> state_r == ST_DIV && step_r == $past(step_r) - 3'd1)
    else $error("divider step sequence broken");

endmodule

// ===== sim/tb_med_residual_block_golomb_param.sv =====
module tb_med_residual_block_golomb_param;
  import mrbg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [7:0] residual;
    logic              block_end;
    logic [7:0]        block_param;
    logic [11:0]       pad_count;
    logic              frame_end;
  } residual_result_t;

  typedef enum int {PAT_NOISE, PAT_RAMP, PAT_EXTREME, PAT_FLAT} pattern_e;

  class residual_param_tracker;
    cfg_t             width_reg;
    cfg_t             height_reg;
    cfg_t             bsize_reg;
    logic [4:0]       shift_reg;
    pix_t             row_mem [MAX_WIDTH];
    pix_t             left_px;
    pix_t             upper_left_px;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    int unsigned      fill_cnt;
    logic [19:0]      abs_sum;
    residual_result_t pending_residuals[$];
    int unsigned      mismatch_count;

    function new();
      width_reg = 4096;
      height_reg = 4096;
      bsize_reg = 64;
      shift_reg = 1;
      foreach (row_mem[i]) row_mem[i] = '0;
      left_px = '0;
      upper_left_px = '0;
      col_cnt = 0;
      row_cnt = 0;
      fill_cnt = 0;
      abs_sum = '0;
      mismatch_count = 0;
    endfunction

    function int unsigned limit_to(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, cfg_t val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        REG_BLOCK_SIZE:   bsize_reg = val;
        REG_QUANT_SHIFT:  shift_reg = val[4:0];
        default: ;
      endcase
    endfunction

    function void accept_pixel(pix_t px);
      int unsigned      w, h, bs, qs, mean;
      int               a, b, c, pred, diff, res;
      pix_t             above;
      logic             row_end, last_px;
      residual_result_t r;
      w = limit_to(width_reg, MAX_WIDTH);
      h = limit_to(height_reg, MAX_HEIGHT);
      bs = limit_to(bsize_reg, MAX_BLOCK);
      qs = (shift_reg == 0) ? 1 : shift_reg;
      above = (col_cnt < MAX_WIDTH) ? row_mem[col_cnt] : '0;
      a = left_px;
      b = above;
      c = upper_left_px;
      if (row_cnt == 0 && col_cnt == 0) begin
        pred = 0;
      end else if (row_cnt == 0) begin
        pred = a;
      end else if (col_cnt == 0) begin
        pred = b;
      end else if (c >= ((a > b) ? a : b)) begin
        pred = (a > b) ? b : a;
      end else if (c <= ((a > b) ? b : a)) begin
        pred = (a > b) ? a : b;
      end else begin
        pred = a + b - c;
      end
      diff = int'(px) - pred;
      res = diff >>> qs;
      if (res > 127) res = 127;
      if (res < -128) res = -128;
      r.residual = res[7:0];
      r.block_end = 1'b0;
      r.block_param = '0;
      r.pad_count = '0;
      if (col_cnt < MAX_WIDTH) row_mem[col_cnt] = px;
      upper_left_px = above;
      left_px = px;
      row_end = (col_cnt + 1 >= w);
      last_px = row_end && (row_cnt + 1 >= h);
      abs_sum = abs_sum + 20'((res < 0) ? -res : res);
      fill_cnt++;
      if (fill_cnt >= bs) begin
        r.block_end = 1'b1;
      end else if (last_px) begin
        r.block_end = 1'b1;
        r.pad_count = 12'(bs - fill_cnt);
      end
      if (r.block_end) begin
        mean = abs_sum / bs;
        if (mean == 0) mean = 1;
        if (mean > 255) mean = 255;
        r.block_param = mean[7:0];
        abs_sum = '0;
        fill_cnt = 0;
      end
      if (row_end) begin
        col_cnt = 0;
        row_cnt = last_px ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
      r.frame_end = last_px;
      pending_residuals.insert(pending_residuals.size(), r);
    endfunction

    function void check_result(residual_result_t got);
      residual_result_t want;
      if (pending_residuals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result without request: res=%0d end=%0b param=%0d pad=%0d fe=%0b",
                   got.residual, got.block_end, got.block_param, got.pad_count, got.frame_end);
        return;
      end
      want = pending_residuals.pop_front();
      if (got.residual !== want.residual || got.block_end !== want.block_end ||
          got.block_param !== want.block_param || got.pad_count !== want.pad_count ||
          got.frame_end !== want.frame_end) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: res/end/param/pad/fe exp %0d/%0b/%0d/%0d/%0b got %0d/%0b/%0d/%0d/%0b",
                   want.residual, want.block_end, want.block_param, want.pad_count,
                   want.frame_end, got.residual, got.block_end, got.block_param,
                   got.pad_count, got.frame_end);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel;
  logic              out_valid;
  logic              out_ready;
  logic signed [7:0] out_residual;
  logic              out_block_end;
  logic [7:0]        out_block_param;
  logic [11:0]       out_pad_count;
  logic              out_frame_end;

  residual_param_tracker tracker;
  residual_result_t      observed;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  bit                    stall_request;
  int unsigned           cycle_count;

  med_residual_block_golomb_param u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_residual   (out_residual),
    .out_block_end  (out_block_end),
    .out_block_param(out_block_param),
    .out_pad_count  (out_pad_count),
    .out_frame_end  (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure plus an occasional long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed.residual = out_residual;
      observed.block_end = out_block_end;
      observed.block_param = out_block_param;
      observed.pad_count = out_pad_count;
      observed.frame_end = out_frame_end;
      tracker.check_result(observed);
    end
  end

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= cfg_t'(val);
    @(posedge clk);
    tracker.set_register(idx, cfg_t'(val));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int unsigned w, h, bs, qs);
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    cfg_write(REG_BLOCK_SIZE, bs);
    cfg_write(REG_QUANT_SHIFT, qs);
  endtask

  task automatic send_pixel(input pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.accept_pixel(p);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_residuals.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned w, h);
    pattern_e pat;
    int       base, dx, dy, v;
    pix_t     p;
    pat = pattern_e'($urandom_range(3));
    base = $urandom_range(255);
    dx = int'($urandom_range(8)) - 4;
    dy = int'($urandom_range(8)) - 4;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (pat)
          PAT_NOISE: p = pix_t'($urandom_range(255));
          PAT_RAMP: begin
            v = base + dx * c + dy * r + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            p = v[7:0];
          end
          PAT_EXTREME: p = $urandom_range(1) ? 8'hFF : 8'h00;
          default: p = base[7:0];
        endcase
        send_pixel(p);
      end
    end
  endtask

  task automatic run_phase(input int unsigned w, h, bs, qs, frames, input bit hold_results,
                           output int unsigned items);
    int unsigned ew, eh;
    set_config(w, h, bs, qs);
    ew = tracker.limit_to(cfg_t'(w), MAX_WIDTH);
    eh = tracker.limit_to(cfg_t'(h), MAX_HEIGHT);
    if (hold_results) stall_request = 1'b1;
    repeat (frames) send_frame(ew, eh);
    drain_results();
    items = frames * ew * eh;
  endtask

  initial begin : stimulus
    int unsigned section_items, n, w, h, bs, qs, pick;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_pixel <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-scale residuals, both median clamps, short block padded at frame end
    set_config(3, 2, 4, 1);
    send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255);
    send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd0);
    drain_results();
    // gradient case, frame ending exactly on a block boundary
    set_config(2, 2, 2, 2);
    send_pixel(8'd20); send_pixel(8'd10); send_pixel(8'd30); send_pixel(8'd25);
    drain_results();
    // zero registers behave as one
    set_config(0, 0, 0, 0);
    send_pixel(8'd200); send_pixel(8'd7);
    drain_results();
    // oversized block, shift beyond 16
    set_config(2, 1, 8191, 31);
    send_pixel(8'd200); send_pixel(8'd3);
    drain_results();
    set_config(1, 1, 8191, 16);
    send_pixel(8'd255);
    drain_results();
    // geometry and block size changed in mid-frame
    set_config(4, 3, 5, 1);
    send_pixel(8'd10); send_pixel(8'd60); send_pixel(8'd110);
    send_pixel(8'd160); send_pixel(8'd90); send_pixel(8'd30);
    drain_results();
    cfg_write(REG_IMAGE_WIDTH, 2);
    cfg_write(REG_IMAGE_HEIGHT, 2);
    cfg_write(REG_BLOCK_SIZE, 3);
    send_pixel(8'd240);
    drain_results();

    for (int section = 0; section < 3; section++) begin
      case (section)
        0: begin send_idle_pct = 7;  recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      section_items = 0;
      if (section == 2) begin
        run_phase(16, 8, 8, 1, 2, 1'b1, n);
        section_items += n;
      end
      while (section_items < 580) begin
        pick = $urandom_range(99);
        w = (pick < 5) ? 0 : (pick < 75) ? $urandom_range(12, 1) : $urandom_range(48, 13);
        pick = $urandom_range(99);
        h = (pick < 5) ? 0 : (pick < 80) ? $urandom_range(4, 1) : $urandom_range(10, 5);
        pick = $urandom_range(99);
        bs = (pick < 6) ? 0 : (pick < 60) ? $urandom_range(8, 1) :
             (pick < 92) ? $urandom_range(64, 9) : $urandom_range(8191, 4096);
        pick = $urandom_range(99);
        qs = (pick < 5) ? 0 : (pick < 60) ? $urandom_range(3, 1) :
             (pick < 92) ? $urandom_range(16, 4) : $urandom_range(31, 17);
        run_phase(w, h, bs, qs, $urandom_range(3, 1), 1'b0, n);
        section_items += n;
      end
    end

    // saturated geometry, frame closed early by shrinking it in mid-frame
    set_config(8191, 8191, 8191, 1);
    repeat (6) send_pixel(pix_t'($urandom_range(255)));
    drain_results();
    cfg_write(REG_IMAGE_WIDTH, 7);
    cfg_write(REG_IMAGE_HEIGHT, 1);
    send_pixel(8'd77);
    drain_results();

    drain_results();
    repeat (20) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_residuals.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
